>>> rtl/matrix4_vector_transform_macros.svh
// Assertion macros shared by the transform block.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef MATRIX4_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define M4VT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define M4VT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/m4vt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform block.
// Depends on nothing.
package m4vt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM = 4;
  localparam int LANE_STAGES = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  localparam logic signed [31:0] ENTRY_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              cmd;
    logic [1:0]        row;
    logic [1:0]        col;
    logic signed [31:0] entry_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic              saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic              sat;
  } lane_res_t;

endpackage

>>> rtl/matrix4_vector_transform.sv
// 4x4 matrix times vector, signed Q16.16; four row lanes and a merge queue.
// Throughput: one transaction per cycle while in_stall is low; set by the four lane
// pipelines in step.
// Reset (rst_n low, synchronous): matrix returns to identity, queue and
// in-flight tracking clear. Depends on m4vt_pkg, m4vt_lane, m4vt_merge and the macros header.
`include "matrix4_vector_transform_macros.svh"

module matrix4_vector_transform
  import m4vt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic signed [31:0]     matrix_r [DIM][DIM];
  logic signed [31:0]     vec [DIM];
  logic [LANE_STAGES-1:0] vld_r;
  logic [CNT_W-1:0]       pending_r;
  logic                   in_accept;
  logic                   load_accept;
  logic                   xform_accept;
  logic                   out_accept;
  lane_res_t              lane_res [DIM];

  // Credit check: every transform in flight or queued owns a queue slot, so
  // the stall comes straight from a register and never from out_stall.
  assign in_stall     = (pending_r == CNT_W'(FIFO_DEPTH));
  assign in_accept    = in_valid && !in_stall;
  assign load_accept  = in_accept && (in_data.cmd == CMD_LOAD);
  assign xform_accept = in_accept && (in_data.cmd == CMD_XFORM);
  assign out_accept   = out_valid && !out_stall;

  assign vec[0] = in_data.vec_x;
  assign vec[1] = in_data.vec_y;
  assign vec[2] = in_data.vec_z;
  assign vec[3] = in_data.vec_w;

  // Matrix store. Lanes multiply against the value held before this edge,
  // so a load takes effect for the transaction after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix_r[r][c] <= (r == c) ? ENTRY_ONE : '0;
        end
      end
    end else if (load_accept) begin
      matrix_r[in_data.row][in_data.col] <= in_data.entry_value;
    end
  end

  // Track transforms through the lane stages and hold the credit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      pending_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_STAGES-2:0], xform_accept};
      if (xform_accept && !out_accept) begin
        pending_r <= pending_r + 1'b1;
      end else if (out_accept && !xform_accept) begin
        pending_r <= pending_r - 1'b1;
      end
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk   (clk),
      .row_i (matrix_r[r]),
      .vec_i (vec),
      .res_o (lane_res[r])
    );
  end

  // Combine lanes and queue the result transaction
  m4vt_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (vld_r[LANE_STAGES-1]),
    .res_i     (lane_res),
    .pop_i     (out_accept),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Transforms in the lanes are always covered by the credit count.
  `M4VT_ASSERT_NOW(a_credit_covers_lanes, 1'b1, $countones(vld_r) <= int'(pending_r),
                   "lane occupancy exceeds credit count")
  // A queued result always belongs to an outstanding transform.
  `M4VT_ASSERT_NOW(a_out_has_credit, out_valid, pending_r != '0,
                   "result presented with no outstanding transform")
  // A load lands in the addressed entry.
  `M4VT_ASSERT_NEXT(a_load_written, load_accept,
                    matrix_r[$past(in_data.row)][$past(in_data.col)] == $past(in_data.entry_value),
                    "matrix load not stored")

endmodule

>>> rtl/m4vt_lane.sv
// One row lane: four products, a two-level adder tree, floor shift and saturation.
// Depends on m4vt_pkg. Always advances; validity is tracked by the caller.
module m4vt_lane
  import m4vt_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] row_i [DIM],
  input  logic signed [31:0] vec_i [DIM],
  output lane_res_t          res_o
);

  logic signed [63:0] prod_r [DIM];
  logic signed [64:0] pair_r [2];
  logic signed [65:0] sum_r;
  logic signed [65:0] shifted;
  logic [65:31]       hi_bits;
  logic               fits;
  lane_res_t          res_nxt;
  lane_res_t          res_r;

  // Stage 1: one 32x32 product per column
  always_ff @(posedge clk) begin
    for (int i = 0; i < DIM; i++) begin
      prod_r[i] <= row_i[i] * vec_i[i];
    end
  end

  // Stage 2 and 3: adder tree
  always_ff @(posedge clk) begin
    pair_r[0] <= 65'(prod_r[0]) + 65'(prod_r[1]);
    pair_r[1] <= 65'(prod_r[2]) + 65'(prod_r[3]);
    sum_r     <= 66'(pair_r[0]) + 66'(pair_r[1]);
  end

  // Stage 4: arithmetic shift rounds toward minus infinity, then clip
  always_comb begin
    shifted = sum_r >>> FRAC_BITS;
    hi_bits = shifted[65:31];
    fits    = (&hi_bits) || !(|hi_bits);
    if (fits) begin
      res_nxt.value = shifted[31:0];
      res_nxt.sat   = 1'b0;
    end else begin
      res_nxt.value = shifted[65] ? SAT_MIN : SAT_MAX;
      res_nxt.sat   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

>>> rtl/m4vt_merge.sv
// Merge stage: joins the four lane results, ORs the clip flags, queues results.
// Depends on m4vt_pkg. The caller bounds occupancy so a push never overflows.
module m4vt_merge
  import m4vt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  lane_res_t res_i [DIM],
  input  logic      pop_i,
  output logic      out_valid,
  output out_item_t out_data
);

  out_item_t        fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  out_item_t        merged;

  always_comb begin
    merged.out_x     = res_i[0].value;
    merged.out_y     = res_i[1].value;
    merged.out_z     = res_i[2].value;
    merged.out_w     = res_i[3].value;
    merged.saturated = res_i[0].sat | res_i[1].sat | res_i[2].sat | res_i[3].sat;
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      fifo_r[wr_ptr_r] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

endmodule

>>> tb/sv/matrix4_vector_transform_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix4_vector_transform: matrix loads and vector transforms
// under random sender bursts and receiver stalls. Depends on m4vt_pkg and the block's RTL.

module matrix4_vector_transform_tb;
  import m4vt_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES = 60;     // long receiver hold-off, enough to fill the block
  localparam int HOLD_BURST = 48;      // transactions offered back to back during the hold
  localparam int SETTLE_CYCLES = 20;   // settle time after the last product, before the verdict
  localparam int WATCHDOG_LIMIT = 2000;

  // Scoreboard: tracks the matrix as the block should see it and queues the
  // products that each transform transaction must produce, in order.
  class product_scoreboard;
    logic signed [31:0] matrix [4][4];
    out_item_t expected_products [$];
    int unsigned errors;

    function new();
      // Start from the identity, as after reset.
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          matrix[r][c] = (r == c) ? ENTRY_ONE : 32'sd0;
        end
      end
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_products.size();
    endfunction

    // Exact 66-bit dot product per row, floor shift, then clip to 32 bits.
    function out_item_t predict_product(in_item_t it);
      logic signed [31:0] vec [4];
      logic signed [31:0] lane [4];
      logic signed [65:0] acc;
      logic signed [65:0] lhs;
      logic signed [65:0] rhs;
      logic signed [65:0] hi_lim;
      logic signed [65:0] lo_lim;
      logic clipped;
      out_item_t res;
      vec[0] = it.vec_x;
      vec[1] = it.vec_y;
      vec[2] = it.vec_z;
      vec[3] = it.vec_w;
      hi_lim = 66'(SAT_MAX);
      lo_lim = 66'(SAT_MIN);
      clipped = 1'b0;
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          lhs = 66'(matrix[r][c]);
          rhs = 66'(vec[c]);
          acc = acc + lhs * rhs;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > hi_lim) begin
          lane[r] = SAT_MAX;
          clipped = 1'b1;
        end else if (acc < lo_lim) begin
          lane[r] = SAT_MIN;
          clipped = 1'b1;
        end else begin
          lane[r] = acc[31:0];
        end
      end
      res.out_x = lane[0];
      res.out_y = lane[1];
      res.out_z = lane[2];
      res.out_w = lane[3];
      res.saturated = clipped;
      return res;
    endfunction

    function void note_input(in_item_t it);
      if (it.cmd == CMD_LOAD) begin
        matrix[it.row][it.col] = it.entry_value;
      end else begin
        expected_products.push_back(predict_product(it));
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_products.size() == 0) begin
        errors++;
        $display("%0t: unexpected product, expected none, actual %0d %0d %0d %0d sat %0d",
                 $time, got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
        return;
      end
      want = expected_products.pop_front();
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_z", want.out_z, got.out_z);
      compare_field("out_w", want.out_w, got.out_w);
      compare_field("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  product_scoreboard products = new();

  // Receiver-side control: the stimulus bumps hold_requests to ask for a long hold.
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned quiet_cycles = 0;

  matrix4_vector_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: sample both channels at the edge, check results before noting
  // new transactions, and end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        products.check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        products.note_input(in_data);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("matrix4_vector_transform_tb failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: a requested long hold takes priority; otherwise
  // pick a mode for a random stretch (never stall, light, heavy, toggle).
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(4, 40);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= ~out_stall;
        end
      endcase
    end
  end

  // Offer one transaction and hold it until the block takes it.
  // Call at a rising edge; returns at the edge of acceptance.
  task automatic push_item(input in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every queued product has come back.
  task automatic wait_for_products();
    in_valid <= 1'b0;
    @(posedge clk);
    while (products.pending() != 0) @(posedge clk);
  endtask

  // Small Q16.16 values half the time so products stay in range, plus extremes and raw bits.
  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  // Load transaction; the vector fields carry junk that the block must ignore.
  function automatic in_item_t load_item(logic [1:0] row, logic [1:0] col,
                                         logic signed [31:0] value);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.row = row;
    it.col = col;
    it.entry_value = value;
    it.vec_x = $urandom;
    it.vec_y = $urandom;
    it.vec_z = $urandom;
    it.vec_w = $urandom;
    return it;
  endfunction

  // Transform transaction; row, col and entry carry junk.
  function automatic in_item_t xform_item(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic signed [31:0] w);
    in_item_t it;
    it.cmd = CMD_XFORM;
    it.row = 2'($urandom_range(0, 3));
    it.col = 2'($urandom_range(0, 3));
    it.entry_value = $urandom;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.vec_w = w;
    return it;
  endfunction

  function automatic in_item_t random_item();
    if ($urandom_range(0, 9) < 3) begin
      return load_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_q());
    end
    return xform_item(pick_q(), pick_q(), pick_q(), pick_q());
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit held;
    bit paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;

    // Hold reset low from the start, then release it once.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Identity after reset: extremes pass through unchanged.
    push_item(xform_item(SAT_MAX, SAT_MIN, 32'sd0, -32'sd1));
    push_item(xform_item(32'sd0, 32'sd0, 32'sd0, 32'sd0));

    // Row 0 saturates high, row 1 low; row 2 checks the floor of a tiny
    // negative product; row 3 mixes a huge negative entry with a tiny one.
    push_item(load_item(2'd0, 2'd0, SAT_MAX));
    push_item(load_item(2'd0, 2'd1, SAT_MAX));
    push_item(load_item(2'd1, 2'd0, SAT_MIN));
    push_item(load_item(2'd1, 2'd1, SAT_MIN));
    push_item(load_item(2'd2, 2'd2, -32'sd1));
    push_item(load_item(2'd2, 2'd3, ENTRY_ONE));
    push_item(load_item(2'd3, 2'd3, 32'sd1));
    push_item(load_item(2'd3, 2'd0, SAT_MIN));
    push_item(xform_item(SAT_MAX, SAT_MAX, 32'sd1, 32'sd1));
    push_item(xform_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    push_item(xform_item(-32'sd1, 32'sd1, 32'sd1, -32'sd1));
    push_item(xform_item(32'sd0, 32'sd0, 32'sd0, 32'sd0));
    push_item(xform_item(ENTRY_ONE, -ENTRY_ONE, SAT_MAX, SAT_MIN));

    // Random part: bursts of transactions with random gaps, sometimes none.
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        push_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_input($urandom_range(1, 12));
      end
      // Ask the receiver for a long hold and keep offering, so the block
      // fills up and stalls its input.
      if (!held && sent >= RANDOM_ITEMS / 3) begin
        held = 1'b1;
        hold_requests++;
        repeat (HOLD_BURST) begin
          push_item(random_item());
          sent++;
        end
      end
      // Pause the sender until the pipeline is empty.
      if (!paused && sent >= 2 * RANDOM_ITEMS / 3) begin
        paused = 1'b1;
        wait_for_products();
      end
    end

    wait_for_products();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (products.errors == 0 && products.pending() == 0) begin
      $display("matrix4_vector_transform_tb passed");
    end else begin
      $display("matrix4_vector_transform_tb failed");
    end
    $finish;
  end

endmodule
